FILE: hdl/dhc_pkg.sv
// Shared widths, constants and lane control type for the dual hue cycler.
`timescale 1ns / 1ps

package dhc_pkg;

  localparam int ELA_BITS = 24;  // elapsed time, Q8.16
  localparam int SPD_BITS = 16;  // cycle speed, Q8.8
  localparam int OFS_BITS = 16;  // hue offset, fraction of a turn
  localparam int SV_BITS  = 17;  // saturation and value, Q1.16
  localparam int CH_BITS  = 8;   // one color channel
  localparam int VS_BITS  = 25;  // value times 255

  localparam logic [SV_BITS-1:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic load;  // take a new term, clear the accumulator
    logic step;  // one shift-add step
    logic mbit;  // multiplier bit for this step
  } lane_ctrl_t;

endpackage

FILE: hdl/dhc_mul_lane.sv
// Bit-serial shift-add multiplier lane, LSB first, keeps the high product bits.
`timescale 1ns / 1ps

module dhc_mul_lane #(
  parameter int TERM_BITS = 33,
  parameter int CH_LSB    = 23
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dhc_pkg::lane_ctrl_t      ctrl_i,
  input  logic [TERM_BITS-1:0]     term_i,
  output logic [dhc_pkg::CH_BITS-1:0] chan_o
);

  logic [TERM_BITS-1:0] term_q;
  logic [TERM_BITS-1:0] acc_q;
  logic [TERM_BITS-1:0] acc_d;
  logic [TERM_BITS:0]   sum;

  // add the term when the multiplier bit is set, then drop the low bit
  assign sum   = {1'b0, acc_q} + (ctrl_i.mbit ? {1'b0, term_q} : {(TERM_BITS + 1){1'b0}});
  assign acc_d = sum[TERM_BITS:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.load) begin
      acc_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      term_q <= term_i;
    end
  end

  assign chan_o = acc_q[CH_LSB +: dhc_pkg::CH_BITS];

endmodule

FILE: hdl/dhc_hsv.sv
// Six-sector HSV to RGB converter built on four bit-serial multiplier lanes.
`timescale 1ns / 1ps

module dhc_hsv #(
  parameter int HUE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [HUE_BITS-1:0]         hue_i,
  input  logic [dhc_pkg::SV_BITS-1:0] sat_i,
  input  logic [dhc_pkg::SV_BITS-1:0] val_i,
  output logic                        done_o,
  output logic [dhc_pkg::CH_BITS-1:0] red_o,
  output logic [dhc_pkg::CH_BITS-1:0] green_o,
  output logic [dhc_pkg::CH_BITS-1:0] blue_o
);

  localparam int TERM_BITS = HUE_BITS + dhc_pkg::SV_BITS;
  localparam int H6_BITS   = HUE_BITS + 3;
  localparam int CH_LSB    = HUE_BITS + 32 - dhc_pkg::VS_BITS;
  localparam int CNT_BITS  = $clog2(dhc_pkg::VS_BITS + 1);
  localparam logic [CNT_BITS-1:0] FS_COUNT  = CNT_BITS'(dhc_pkg::SV_BITS);
  localparam logic [CNT_BITS-1:0] MUL_COUNT = CNT_BITS'(dhc_pkg::VS_BITS);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_FS   = 2'd1;
  localparam logic [1:0] H_LOAD = 2'd2;
  localparam logic [1:0] H_MUL  = 2'd3;

  localparam logic [2:0] SEC_R2Y = 3'd0;
  localparam logic [2:0] SEC_Y2G = 3'd1;
  localparam logic [2:0] SEC_G2C = 3'd2;
  localparam logic [2:0] SEC_C2B = 3'd3;
  localparam logic [2:0] SEC_B2M = 3'd4;

  logic [1:0]                  st_q;
  logic [CNT_BITS-1:0]         cnt_q;
  logic                        done_q;
  logic [2:0]                  sector_q;
  logic [HUE_BITS-1:0]         f_q;
  logic [dhc_pkg::SV_BITS-1:0] s_q;
  logic [dhc_pkg::SV_BITS-1:0] sh_q;
  logic [TERM_BITS-1:0]        fs_q;
  logic [dhc_pkg::VS_BITS-1:0] vs_q;

  logic [H6_BITS-1:0]          h6;
  logic [dhc_pkg::SV_BITS-1:0] sat_lim;
  logic [dhc_pkg::SV_BITS-1:0] val_lim;
  logic [TERM_BITS-1:0]        term_v;
  logic [TERM_BITS-1:0]        term_p;
  logic [TERM_BITS-1:0]        term_q_s;
  logic [TERM_BITS-1:0]        term_t;
  logic [dhc_pkg::CH_BITS-1:0] ch_v;
  logic [dhc_pkg::CH_BITS-1:0] ch_p;
  logic [dhc_pkg::CH_BITS-1:0] ch_q;
  logic [dhc_pkg::CH_BITS-1:0] ch_t;
  dhc_pkg::lane_ctrl_t         ctrl;

  assign h6      = (H6_BITS'(hue_i) << 2) + (H6_BITS'(hue_i) << 1);
  assign sat_lim = (sat_i > dhc_pkg::ONE_Q16) ? dhc_pkg::ONE_Q16 : sat_i;
  assign val_lim = (val_i > dhc_pkg::ONE_Q16) ? dhc_pkg::ONE_Q16 : val_i;

  // sequencer: f*s, load terms, then value*255 times each term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= H_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (st_q == H_MUL) && (cnt_q == CNT_BITS'(1));
      unique case (st_q)
        H_IDLE: begin
          if (start_i) begin
            st_q  <= H_FS;
            cnt_q <= FS_COUNT;
          end
        end
        H_FS: begin
          cnt_q <= cnt_q - CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(1)) begin
            st_q <= H_LOAD;
          end
        end
        H_LOAD: begin
          st_q  <= H_MUL;
          cnt_q <= MUL_COUNT;
        end
        H_MUL: begin
          cnt_q <= cnt_q - CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(1)) begin
            st_q <= H_IDLE;
          end
        end
        default: begin
          st_q <= H_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == H_IDLE && start_i) begin
      sector_q <= h6[HUE_BITS +: 3];
      f_q      <= h6[HUE_BITS-1:0];
      s_q      <= sat_lim;
      sh_q     <= sat_lim;
      fs_q     <= '0;
      vs_q     <= (dhc_pkg::VS_BITS'(val_lim) << dhc_pkg::CH_BITS)
                  - dhc_pkg::VS_BITS'(val_lim);
    end else if (st_q == H_FS) begin
      // MSB-first shift-add of f times s
      fs_q <= (fs_q << 1)
              + (sh_q[dhc_pkg::SV_BITS-1] ? TERM_BITS'(f_q) : TERM_BITS'(0));
      sh_q <= sh_q << 1;
    end else if (st_q == H_MUL) begin
      vs_q <= vs_q >> 1;
    end
  end

  // (1 - (1 - f) * s) equals (1 - s) + f * s in this scaling
  assign term_v   = TERM_BITS'(1) << (HUE_BITS + 16);
  assign term_p   = TERM_BITS'(dhc_pkg::ONE_Q16 - s_q) << HUE_BITS;
  assign term_q_s = term_v - fs_q;
  assign term_t   = term_p + fs_q;

  assign ctrl.load = (st_q == H_LOAD);
  assign ctrl.step = (st_q == H_MUL);
  assign ctrl.mbit = vs_q[0];

  dhc_mul_lane #(.TERM_BITS(TERM_BITS), .CH_LSB(CH_LSB)) u_lane_v (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .term_i(term_v), .chan_o(ch_v)
  );
  dhc_mul_lane #(.TERM_BITS(TERM_BITS), .CH_LSB(CH_LSB)) u_lane_p (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .term_i(term_p), .chan_o(ch_p)
  );
  dhc_mul_lane #(.TERM_BITS(TERM_BITS), .CH_LSB(CH_LSB)) u_lane_q (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .term_i(term_q_s), .chan_o(ch_q)
  );
  dhc_mul_lane #(.TERM_BITS(TERM_BITS), .CH_LSB(CH_LSB)) u_lane_t (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .term_i(term_t), .chan_o(ch_t)
  );

  always_comb begin
    case (sector_q)
      SEC_R2Y: begin red_o = ch_v; green_o = ch_t; blue_o = ch_p; end
      SEC_Y2G: begin red_o = ch_q; green_o = ch_v; blue_o = ch_p; end
      SEC_G2C: begin red_o = ch_p; green_o = ch_v; blue_o = ch_t; end
      SEC_C2B: begin red_o = ch_p; green_o = ch_q; blue_o = ch_v; end
      SEC_B2M: begin red_o = ch_t; green_o = ch_p; blue_o = ch_v; end
      default: begin red_o = ch_v; green_o = ch_p; blue_o = ch_q; end
    endcase
  end

  assign done_o = done_q;

endmodule

FILE: hdl/dhc_phase.sv
// Hue phase accumulator with a bit-serial elapsed times speed multiplier.
`timescale 1ns / 1ps

module dhc_phase #(
  parameter int HUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dhc_pkg::ELA_BITS-1:0] elapsed_i,
  input  logic [dhc_pkg::SPD_BITS-1:0] speed_i,
  output logic                         done_o,
  output logic [HUE_BITS-1:0]          hue_o
);

  localparam int PHASE_BITS = 32;
  localparam int ACC_BITS   = PHASE_BITS - 2;
  localparam int CNT_BITS   = $clog2(dhc_pkg::SPD_BITS + 1);
  localparam logic [CNT_BITS-1:0] CNT_LOAD = CNT_BITS'(dhc_pkg::SPD_BITS);

  logic                         busy_q;
  logic                         commit_q;
  logic                         done_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic [dhc_pkg::SPD_BITS-1:0] spd_q;
  logic [dhc_pkg::ELA_BITS-1:0] ela_q;
  logic [ACC_BITS-1:0]          acc_q;
  logic [PHASE_BITS-1:0]        phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      commit_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      phase_q  <= '0;
    end else begin
      commit_q <= busy_q && (cnt_q == CNT_BITS'(1));
      done_q   <= commit_q;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_LOAD;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
        end
      end
      // product times four, wrapping modulo one turn
      if (commit_q) begin
        phase_q <= phase_q + {acc_q, 2'b00};
      end
    end
  end

  // MSB first over the speed bits; only the low product bits survive the wrap
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ela_q <= elapsed_i;
      spd_q <= speed_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << 1)
               + (spd_q[dhc_pkg::SPD_BITS-1] ? ACC_BITS'(ela_q) : ACC_BITS'(0));
      spd_q <= spd_q << 1;
    end
  end

  assign done_o = done_q;
  assign hue_o  = phase_q[PHASE_BITS-1 -: HUE_BITS];

endmodule

FILE: hdl/dual_hue_cycle_hsv_to_rgb.sv
// Top level of the dual hue cycler: register file, sequencing and result register.
// An accepted tick passes the serial speed multiply (16 steps), the serial f*s multiply
// (17 steps) and the 25-step value multiply in each lane before its result reaches the
// output register; no new tick is taken until the converters have finished the last one.
// A ticked request is taken while the previous result still waits on the output.
// Reset (rst_ni low, asynchronous): hue phase zero, registers to their defaults.
`timescale 1ns / 1ps

module dual_hue_cycle_hsv_to_rgb #(
  parameter int HUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tick requests
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dhc_pkg::ELA_BITS-1:0] elapsed_i,
  input  logic                         second_player_i,
  // color results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dhc_pkg::CH_BITS-1:0]  red_first_o,
  output logic [dhc_pkg::CH_BITS-1:0]  green_first_o,
  output logic [dhc_pkg::CH_BITS-1:0]  blue_first_o,
  output logic [dhc_pkg::CH_BITS-1:0]  red_second_o,
  output logic [dhc_pkg::CH_BITS-1:0]  green_second_o,
  output logic [dhc_pkg::CH_BITS-1:0]  blue_second_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // register map, one word per register
  localparam logic [2:0] REG_SPEED  = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_SAT1   = 3'd2;
  localparam logic [2:0] REG_VAL1   = 3'd3;
  localparam logic [2:0] REG_SAT2   = 3'd4;
  localparam logic [2:0] REG_VAL2   = 3'd5;
  localparam logic [2:0] REG_SKIP   = 3'd6;

  localparam logic [dhc_pkg::SPD_BITS-1:0] SPEED_RESET = 16'd256;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PHASE = 2'd1;
  localparam logic [1:0] S_HSV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [dhc_pkg::SPD_BITS-1:0] speed_q;
  logic [dhc_pkg::OFS_BITS-1:0] offset_q;
  logic [dhc_pkg::SV_BITS-1:0]  sat1_q;
  logic [dhc_pkg::SV_BITS-1:0]  val1_q;
  logic [dhc_pkg::SV_BITS-1:0]  sat2_q;
  logic [dhc_pkg::SV_BITS-1:0]  val2_q;
  logic                         skip_q;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;

  logic [dhc_pkg::CH_BITS-1:0] r1_q, g1_q, b1_q, r2_q, g2_q, b2_q;
  logic [dhc_pkg::CH_BITS-1:0] r1, g1, b1, r2, g2, b2;

  logic                        cfg_wr;
  logic [2:0]                  cfg_idx;
  logic                        accept;
  logic                        skip_hit;
  logic                        phase_start;
  logic                        phase_done;
  logic [HUE_BITS-1:0]         hue1;
  logic [HUE_BITS-1:0]         hue2;
  logic [HUE_BITS-1:0]         hue_ofs;
  logic [dhc_pkg::OFS_BITS+7:0] ofs_wide;
  logic                        done1;
  logic                        done2;
  logic                        slot_free;
  logic                        deliver;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; no wait states.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RESET;
      offset_q <= '0;
      sat1_q   <= dhc_pkg::ONE_Q16;
      val1_q   <= dhc_pkg::ONE_Q16;
      sat2_q   <= dhc_pkg::ONE_Q16;
      val2_q   <= dhc_pkg::ONE_Q16;
      skip_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPEED:  speed_q  <= pwdata[dhc_pkg::SPD_BITS-1:0];
        REG_OFFSET: offset_q <= pwdata[dhc_pkg::OFS_BITS-1:0];
        REG_SAT1:   sat1_q   <= pwdata[dhc_pkg::SV_BITS-1:0];
        REG_VAL1:   val1_q   <= pwdata[dhc_pkg::SV_BITS-1:0];
        REG_SAT2:   sat2_q   <= pwdata[dhc_pkg::SV_BITS-1:0];
        REG_VAL2:   val2_q   <= pwdata[dhc_pkg::SV_BITS-1:0];
        REG_SKIP:   skip_q   <= pwdata[0];
        default: begin
          // unmapped word: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPEED:  prdata = 32'(speed_q);
      REG_OFFSET: prdata = 32'(offset_q);
      REG_SAT1:   prdata = 32'(sat1_q);
      REG_VAL1:   prdata = 32'(val1_q);
      REG_SAT2:   prdata = 32'(sat2_q);
      REG_VAL2:   prdata = 32'(val2_q);
      REG_SKIP:   prdata = 32'(skip_q);
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tick intake. A second-player tick with skip enabled is accepted and dropped:
  // no result, phase untouched.
  // ---------------------------------------------------------------------------
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign skip_hit    = skip_q && second_player_i;
  assign phase_start = accept && !skip_hit;

  dhc_phase #(.HUE_BITS(HUE_BITS)) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (phase_start),
    .elapsed_i (elapsed_i),
    .speed_i   (speed_q),
    .done_o    (phase_done),
    .hue_o     (hue1)
  );

  // Align the 16-bit offset to the hue width: low bits drop for narrow hues,
  // zeros fill in for wide ones. The hue sum wraps modulo one turn.
  assign ofs_wide = {offset_q, 8'h00};
  assign hue_ofs  = ofs_wide[dhc_pkg::OFS_BITS+7 -: HUE_BITS];
  assign hue2     = hue1 + hue_ofs;

  // Both colors run side by side on identical converters.
  dhc_hsv #(.HUE_BITS(HUE_BITS)) u_hsv_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (phase_done),
    .hue_i   (hue1),
    .sat_i   (sat1_q),
    .val_i   (val1_q),
    .done_o  (done1),
    .red_o   (r1),
    .green_o (g1),
    .blue_o  (b1)
  );

  dhc_hsv #(.HUE_BITS(HUE_BITS)) u_hsv_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (phase_done),
    .hue_i   (hue2),
    .sat_i   (sat2_q),
    .val_i   (val2_q),
    .done_o  (done2),
    .red_o   (r2),
    .green_o (g2),
    .blue_o  (b2)
  );

  // ---------------------------------------------------------------------------
  // Sequencing and output register. A finished result moves into the output
  // register as soon as it is empty or being drained; otherwise hold in S_DONE.
  // The converters keep their channels stable until their next start.
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_q || out_ready_i;
  assign deliver   = ((state_q == S_HSV && done1) || state_q == S_DONE) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (phase_start) begin
          state_d = S_PHASE;
        end
      end
      S_PHASE: begin
        if (phase_done) begin
          state_d = S_HSV;
        end
      end
      S_HSV: begin
        if (done1) begin
          state_d = slot_free ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (deliver) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      r1_q <= r1;
      g1_q <= g1;
      b1_q <= b1;
      r2_q <= r2;
      g2_q <= g2;
      b2_q <= b2;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_first_o    = r1_q;
  assign green_first_o  = g1_q;
  assign blue_first_o   = b1_q;
  assign red_second_o   = r2_q;
  assign green_second_o = g2_q;
  assign blue_second_o  = b2_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done1 == done2)
    else $error("color converters finished in different cycles");

  a_skip_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && skip_hit) |=> (state_q == S_IDLE))
    else $error("skipped tick started work");

  a_tick_starts_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_start |=> (state_q == S_PHASE))
    else $error("accepted tick did not start the phase update");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_HSV || state_q == S_DONE))
    else $error("result appeared without a finished conversion");

endmodule
